// ===== rtl/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int SHIFT_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int CNT_W       = $clog2(CELL_COUNT + 1);

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SETCUR = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;
  localparam int                TAB_STEP     = 8;

  localparam logic [CELL_W-1:0] BLANK_CELL_RESET = 16'h0F20;
  localparam logic [CLR_W-1:0]  FG_RESET         = 4'hF;
  localparam logic [CLR_W-1:0]  BG_RESET         = 4'h0;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/tcw_in_if.sv =====
// Command channel interface: valid/ready plus one console command.
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  target_col;
  logic [ROW_W-1:0]  target_row;

  modport source (output valid, opcode, char_code, target_col, target_row, input ready);
  modport sink   (input valid, opcode, char_code, target_col, target_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcw_out_if.sv =====
// Result channel interface: valid/ready plus cursor and cell status.
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LIN_W-1:0]  cursor_linear;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic [CELL_W-1:0] cell_value;
  logic              did_scroll;
  logic              rejected;

  modport source (output valid, cursor_linear, cursor_column, cursor_line, cell_value,
                  did_scroll, rejected, input ready);
  modport sink   (input valid, cursor_linear, cursor_column, cursor_line, cell_value,
                  did_scroll, rejected, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Text console engine: screen store, cursor sequencer and APB color registers.
// Put char, set cursor: accept in S_IDLE, then S_EXEC, S_LINEAR and S_DONE; a read in range adds S_RDWAIT.
// Scroll adds an S_SCROLL pass (one store word moved per cycle over one read port and one write port);
// clear adds an S_FILL pass (one store word written per cycle).
// A new command is taken only once the last result is loaded; ready only while the sequencer idles.
// Reset: a clearing pass over all CELL_COUNT cells fills the store with blanks; ready stays low.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tcw_in_if.sink           in_if,
  tcw_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_LINEAR = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CLR_W-1:0]  fg_r, bg_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  opcode_t           op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]  tcol_r;
  logic [ROW_W-1:0]  trow_r;

  logic              scroll_r, scroll_nxt;
  logic              rej_r, rej_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [LIN_W-1:0]  lin_r, lin_nxt;

  logic              pend_r, pend_nxt;
  logic              pend_blank_r, pend_blank_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;

  logic              out_valid_r;
  logic [LIN_W-1:0]  out_lin_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_scroll_r;
  logic              out_rej_r;

  logic              in_acc;
  logic              out_load;
  logic              cfg_wr;

  // Screen store: one write port, one registered read port.
  logic [CELL_W-1:0] cells_mem [CELL_COUNT];
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data_r;

  // Shared address unit: row * COLUMNS + col.
  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] au_sum;

  // Put-char decode.
  logic [7:0]        pc_col;
  logic [5:0]        pc_row;
  logic [COL_W-1:0]  pc_wr_col;
  logic [CHAR_W-1:0] pc_wr_char;
  logic              pc_wr;
  logic              pc_scroll;
  logic              tgt_inside;
  logic [CELL_W-1:0] color_blank;

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;
  assign prdata      = paddr[2] ? {28'd0, bg_r} : {28'd0, fg_r};
  assign color_blank = {bg_r, fg_r, CH_BLANK};
  assign tgt_inside  = (tcol_r < COL_W'(COLUMNS)) && (trow_r < ROW_W'(ROWS));

  assign au_sum = ADDR_W'(au_row) * ADDR_W'(COLUMNS) + ADDR_W'(au_col);

  always_comb begin
    if (state_r == S_EXEC && op_r == OP_READ) begin
      au_row = trow_r;
      au_col = tcol_r;
    end else if (state_r == S_EXEC) begin
      au_row = cur_row_r;
      au_col = pc_wr_col;
    end else begin
      au_row = cur_row_r;
      au_col = cur_col_r;
    end
  end

  always_comb begin
    pc_col     = {1'b0, cur_col_r};
    pc_row     = {1'b0, cur_row_r};
    pc_wr_col  = cur_col_r;
    pc_wr_char = ch_r;
    pc_wr      = 1'b0;
    unique case (ch_r)
      CH_NEWLINE: begin
        pc_col = 8'd0;
        pc_row = pc_row + 6'd1;
      end
      CH_RETURN: pc_col = 8'd0;
      CH_TAB:    pc_col = (pc_col + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
      CH_BACKSPACE: begin
        if (cur_col_r != '0) begin
          pc_col     = pc_col - 8'd1;
          pc_wr_col  = cur_col_r - COL_W'(1);
          pc_wr_char = CH_BLANK;
          pc_wr      = 1'b1;
        end
      end
      default: begin
        pc_col = pc_col + 8'd1;
        pc_wr  = 1'b1;
      end
    endcase
    // wrap to the next line on column overflow
    if (pc_col >= 8'(COLUMNS)) begin
      pc_col = 8'd0;
      pc_row = pc_row + 6'd1;
    end
    pc_scroll = (pc_row >= 6'(ROWS));
  end

  // Store port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = au_sum;
    wr_data = {bg_r, fg_r, pc_wr_char};
    rd_en   = 1'b0;
    rd_addr = au_sum;
    priority if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = pend_blank_r ? color_blank : rd_data_r;
    end else if (state_r == S_INIT) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[ADDR_W-1:0];
      wr_data = BLANK_CELL_RESET;
    end else if (state_r == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[ADDR_W-1:0];
      wr_data = color_blank;
    end else if (state_r == S_EXEC && op_r == OP_PUT) begin
      wr_en = pc_wr;
    end else begin
      wr_en = 1'b0;
    end
    if (state_r == S_SCROLL) begin
      rd_addr = cnt_r[ADDR_W-1:0] + ADDR_W'(COLUMNS);
      rd_en   = (cnt_r < CNT_W'(SHIFT_CELLS));
    end else begin
      rd_en = (state_r == S_EXEC) && (op_r == OP_READ) && tgt_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cells_mem[rd_addr];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    cnt_nxt        = cnt_r;
    scroll_nxt     = scroll_r;
    rej_nxt        = rej_r;
    cell_nxt       = cell_r;
    lin_nxt        = lin_r;
    pend_nxt       = 1'b0;
    pend_blank_nxt = pend_blank_r;
    pend_addr_nxt  = pend_addr_r;
    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        scroll_nxt = 1'b0;
        rej_nxt    = 1'b0;
        cell_nxt   = '0;
        cnt_nxt    = '0;
        unique case (op_r)
          OP_PUT: begin
            cur_col_nxt = pc_col[COL_W-1:0];
            if (pc_scroll) begin
              cur_row_nxt = ROW_W'(ROWS - 1);
              scroll_nxt  = 1'b1;
              state_nxt   = S_SCROLL;
            end else begin
              cur_row_nxt = pc_row[ROW_W-1:0];
              state_nxt   = S_LINEAR;
            end
          end
          OP_CLEAR: state_nxt = S_FILL;
          OP_SETCUR: begin
            if (tgt_inside) begin
              cur_col_nxt = tcol_r;
              cur_row_nxt = trow_r;
            end else begin
              rej_nxt = 1'b1;
            end
            state_nxt = S_LINEAR;
          end
          OP_READ: begin
            if (tgt_inside) begin
              state_nxt = S_RDWAIT;
            end else begin
              rej_nxt   = 1'b1;
              state_nxt = S_LINEAR;
            end
          end
          default: state_nxt = S_LINEAR;
        endcase
      end
      S_RDWAIT: begin
        cell_nxt  = rd_data_r;
        state_nxt = S_LINEAR;
      end
      S_SCROLL: begin
        // issue one move (or blank) per cycle; the write is made from the registered pend_* fields
        if (cnt_r < CNT_W'(CELL_COUNT)) begin
          pend_nxt       = 1'b1;
          pend_addr_nxt  = cnt_r[ADDR_W-1:0];
          pend_blank_nxt = (cnt_r >= CNT_W'(SHIFT_CELLS));
          cnt_nxt        = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_LINEAR;
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CELL_COUNT - 1)) begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          state_nxt   = S_LINEAR;
        end
      end
      S_LINEAR: begin
        lin_nxt   = LIN_W'(au_sum);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      pend_r    <= pend_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          CFG_FG:  fg_r <= pwdata[CLR_W-1:0];
          CFG_BG:  bg_r <= pwdata[CLR_W-1:0];
          default: fg_r <= fg_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= opcode_t'(in_if.opcode);
      ch_r   <= in_if.char_code;
      tcol_r <= in_if.target_col;
      trow_r <= in_if.target_row;
    end
    scroll_r     <= scroll_nxt;
    rej_r        <= rej_nxt;
    cell_r       <= cell_nxt;
    lin_r        <= lin_nxt;
    pend_blank_r <= pend_blank_nxt;
    pend_addr_r  <= pend_addr_nxt;
    if (out_load) begin
      out_lin_r    <= lin_r;
      out_col_r    <= cur_col_r;
      out_row_r    <= cur_row_r;
      out_cell_r   <= cell_r;
      out_scroll_r <= scroll_r;
      out_rej_r    <= rej_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.cursor_linear = out_lin_r;
  assign out_if.cursor_column = out_col_r;
  assign out_if.cursor_line   = out_row_r;
  assign out_if.cell_value    = out_cell_r;
  assign out_if.did_scroll    = out_scroll_r;
  assign out_if.rejected      = out_rej_r;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < COL_W'(COLUMNS)) && (cur_row_r < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_no_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("store written while sequencer idle");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && scroll_r) |=> (out_if.cursor_line == ROW_W'(ROWS - 1)))
    else $error("scroll did not leave cursor on last row");

  a_reject_only_addr_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && rej_r) |-> (op_r == OP_SETCUR || op_r == OP_READ))
    else $error("reject flagged on put or clear");

  a_scroll_only_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (op_r == OP_PUT && scroll_r))
    else $error("scroll pass without a put transaction");
`endif

endmodule

`default_nettype wire
